// ===== src/vertex_dedup_indexer_macros.svh =====
// Assertion macros shared by the vertex dedup indexer RTL.
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every clock edge outside reset.
`define VDI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VDI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/vdi_pkg.sv =====
// Package with types and constants of the vertex dedup indexer.
`timescale 1ns / 1ps
package vdi_pkg;
    localparam int DefTableDepth = 1024;
    localparam int Components    = 8;
    localparam int CompWidth     = 32;
    localparam int EntryWidth    = Components * CompWidth;
    localparam int IndexWidth    = 10;

    typedef struct packed {
        logic        new_mesh;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
    } t_in_word;

    typedef struct packed {
        logic [IndexWidth-1:0] vertex_index;
        logic                  is_new;
        logic                  overflow;
    } t_out_word;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture corner, clear count on new mesh
        logic rd_first; // start read of entry 0
        logic rd_next;  // advance read address
        logic cmp;      // read data valid: compare
        logic finish;   // write result, append if needed
    } t_vdi_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;    // no stored entries
        logic hit;      // compared entry matches
        logic last;     // compared entry is the last stored one
    } t_vdi_sts;

    // IEEE single equality on raw bit patterns.
    function automatic logic word_equal(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:0] > 31'h7F800000);
        b_nan = (b[30:0] > 31'h7F800000);
        word_equal = !a_nan && !b_nan &&
                     ((a[30:0] == '0 && b[30:0] == '0) || a == b);
    endfunction
endpackage

// ===== src/vertex_dedup_indexer.sv =====
// Vertex dedup indexer top level: ties controller and datapath together.
// Each corner is compared in insertion order against the stored unique
// vertices, one table read per cycle from a single registered-read memory
// port. A corner is handled to the end before the next one is accepted,
// and a result waits while the output register holds a stalled one.
// Results return the matching or appended index, with is_new set on an
// append (the consumer captures the vertex) and overflow set when the table
// is full. new_mesh empties the table before the corner is handled.
`timescale 1ns / 1ps
module vertex_dedup_indexer #(
    parameter int TABLE_DEPTH = vdi_pkg::DefTableDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vdi_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output vdi_pkg::t_out_word o_word
);
    import vdi_pkg::*;

    t_vdi_cmd w_cmd;
    t_vdi_sts w_sts;

    vdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    vdi_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_word)
    );
endmodule

// ===== src/vdi_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module vdi_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/vdi_datapath.sv =====
// Datapath: corner register, entry count, table memory, compare and result.
`timescale 1ns / 1ps
module vdi_datapath #(
    parameter int TableDepth = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vdi_pkg::t_in_word     i_word,
    input  vdi_pkg::t_vdi_cmd     i_cmd,
    output vdi_pkg::t_vdi_sts     o_sts,
    output vdi_pkg::t_out_word    o_result
);
    import vdi_pkg::*;

    localparam int AddrWidth  = $clog2(TableDepth);
    localparam int CountWidth = $clog2(TableDepth + 1);

    logic [EntryWidth-1:0] r_corner;
    logic [CountWidth-1:0] r_count;
    logic [CountWidth-1:0] n_count;
    logic [AddrWidth-1:0]  r_raddr;
    logic [AddrWidth-1:0]  n_raddr;
    logic [AddrWidth-1:0]  r_cmp_addr;
    logic [AddrWidth-1:0]  r_hit_addr;
    logic                  r_found;
    logic [EntryWidth-1:0] w_rdata;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_we;
    t_out_word             r_result;
    t_out_word             n_result;

    // Compare every component of the stored entry.
    always_comb begin
        w_hit = 1'b1;
        for (int c = 0; c < Components; c++) begin
            if (!word_equal(r_corner[c*CompWidth +: CompWidth],
                            w_rdata[c*CompWidth +: CompWidth])) begin
                w_hit = 1'b0;
            end
        end
    end

    assign w_full = (r_count == CountWidth'(TableDepth));
    assign w_we   = i_cmd.finish && !r_found && !w_full;

    vdi_ram #(.Width(EntryWidth), .Depth(TableDepth)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AddrWidth-1:0]),
        .i_wdata (r_corner),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    // Advance read address.
    always_comb begin
        n_raddr = r_raddr;
        if (i_cmd.rd_first) begin
            n_raddr = '0;
        end else if (i_cmd.rd_next) begin
            n_raddr = r_raddr + AddrWidth'(1);
        end
    end

    // Build the result word and the new count.
    always_comb begin
        n_count  = r_count;
        n_result = r_result;
        if (i_cmd.load && i_word.new_mesh) begin
            n_count = '0;
        end
        if (i_cmd.finish) begin
            if (r_found) begin
                n_result.vertex_index = IndexWidth'(r_hit_addr);
                n_result.is_new       = 1'b0;
                n_result.overflow     = 1'b0;
            end else if (w_full) begin
                n_result.vertex_index = '0;
                n_result.is_new       = 1'b0;
                n_result.overflow     = 1'b1;
            end else begin
                n_result.vertex_index = IndexWidth'(r_count);
                n_result.is_new       = 1'b1;
                n_result.overflow     = 1'b0;
                n_count               = r_count + CountWidth'(1);
            end
        end
    end

    // Clear count and found flag under reset; otherwise update them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp && w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    // Capture payload, hit address, read addresses and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_corner <= {i_word.pos_x, i_word.pos_y, i_word.pos_z, i_word.norm_x,
                         i_word.norm_y, i_word.norm_z, i_word.tex_u, i_word.tex_v};
        end
        if (i_cmd.cmp && w_hit) begin
            r_hit_addr <= r_cmp_addr;
        end
        r_cmp_addr <= r_raddr;
        r_raddr    <= n_raddr;
        r_result   <= n_result;
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.hit   = w_hit;
    assign o_sts.last  = (CountWidth'(r_cmp_addr) == CountWidth'(r_count - CountWidth'(1)));
    assign o_result    = r_result;

`include "vertex_dedup_indexer_macros.svh"
    `VDI_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CountWidth'(TableDepth))
    `VDI_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, w_we, r_count == $past(r_count) + 1'b1)
    `VDI_ASSERT_IMP(a_no_write_on_hit, i_clk, i_rst_n, r_found, !w_we)
endmodule

// ===== src/vdi_ctrl.sv =====
// Controller: sequences the table scan and the output handshake.
`timescale 1ns / 1ps
module vdi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  vdi_pkg::t_vdi_sts i_sts,
    output vdi_pkg::t_vdi_cmd o_cmd
);
    import vdi_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StStart = 3'd1;
    localparam logic [2:0] StRead  = 3'd2;
    localparam logic [2:0] StCmp   = 3'd3;
    localparam logic [2:0] StDone  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_valid;
    logic       n_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_out_free = !r_valid || !i_stall;
    assign w_accept   = i_valid && (r_state == StIdle);
    assign o_stall    = (r_state != StIdle);
    assign o_valid    = r_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        case (r_state)
            StIdle: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = StStart;
                end
            end
            StStart: begin
                if (i_sts.empty) begin
                    n_state = StDone;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = StRead;
                end
            end
            StRead: begin
                o_cmd.rd_next = 1'b1;
                n_state       = StCmp;
            end
            StCmp: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.hit || i_sts.last) begin
                    n_state = StDone;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            StDone: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

`include "vertex_dedup_indexer_macros.svh"
    `VDI_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.load, o_cmd.finish}))
    `VDI_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, o_cmd.finish, o_valid)
    `VDI_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, o_cmd.load, i_valid && !o_stall)
endmodule
